FILE: rtl/kic_pkg.sv
`timescale 1ns / 1ps

package kic_pkg;

   // value fields are 31-bit signed, magnitudes stay below 2**30
   localparam int VAL_W  = 31;
   localparam int MAG_W  = 30;
   localparam int PROD_W = 2 * MAG_W;

   // nine-digit display limit, 10**9 - 1
   localparam logic signed [VAL_W-1:0] LIMIT = 31'sd999999999;

   // key action codes, carried on req_tuser
   localparam logic [3:0] ACT_DIGIT = 4'd0;
   localparam logic [3:0] ACT_ADD   = 4'd1;
   localparam logic [3:0] ACT_SUB   = 4'd2;
   localparam logic [3:0] ACT_MUL   = 4'd3;
   localparam logic [3:0] ACT_DIV   = 4'd4;
   localparam logic [3:0] ACT_EQUAL = 4'd5;
   localparam logic [3:0] ACT_CLEAR = 4'd6;
   localparam logic [3:0] ACT_MCLR  = 4'd7;
   localparam logic [3:0] ACT_MRCL  = 4'd8;
   localparam logic [3:0] ACT_MADD  = 4'd9;
   localparam logic [3:0] ACT_MSUB  = 4'd10;

   // pending operation codes
   localparam logic [2:0] PEND_ADD   = 3'd0;
   localparam logic [2:0] PEND_SUB   = 3'd1;
   localparam logic [2:0] PEND_MUL   = 3'd2;
   localparam logic [2:0] PEND_DIV   = 3'd3;
   localparam logic [2:0] PEND_EQUAL = 3'd4;

   typedef logic signed [VAL_W-1:0] value_type;

   // request into the shared multiply/divide unit
   typedef struct packed {
      logic             start;
      logic             divide;
      logic [MAG_W-1:0] opa;     // multiplicand or dividend
      logic [MAG_W-1:0] opb;     // multiplier or divisor
   } unit_req_type;

   // status out of the shared unit
   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] result; // product, or quotient in the low half
   } unit_rsp_type;

endpackage

FILE: rtl/kic_unit.sv
`timescale 1ns / 1ps

// Radix-2 shift-add multiplier / restoring divider on unsigned magnitudes.
// One 32-bit adder does the work of both; one bit per cycle.
module kic_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  kic_pkg::unit_req_type req,
   output kic_pkg::unit_rsp_type rsp
);

   localparam int MW    = kic_pkg::MAG_W;
   localparam int CNT_W = $clog2(MW);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MW - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             divide_ff, divide_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [MW:0]      hi_ff, hi_in;
   logic [MW-1:0]    lo_ff, lo_in;
   logic [MW-1:0]    opnd_ff, opnd_in;

   logic [MW:0]      add_x;
   logic [MW:0]      add_y;
   logic [MW+1:0]    add_sum;

   // shared adder: add multiplicand, or trial-subtract divisor
   always_comb begin
      if (divide_ff) begin
         add_x = {hi_ff[MW-1:0], lo_ff[MW-1]};
         add_y = ~{1'b0, opnd_ff};
      end else begin
         add_x = {1'b0, hi_ff[MW-1:0]};
         add_y = lo_ff[0] ? {1'b0, opnd_ff} : '0;
      end
   end

   assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{(MW+1){1'b0}}, divide_ff};

   // step sequencer
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      divide_in = divide_ff;
      count_in  = count_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      opnd_in   = opnd_ff;
      if (req.start) begin
         busy_in   = 1'b1;
         divide_in = req.divide;
         count_in  = '0;
         hi_in     = '0;
         lo_in     = req.divide ? req.opa : req.opb;
         opnd_in   = req.divide ? req.opb : req.opa;
      end else if (busy_ff) begin
         count_in = count_ff + 1'b1;
         if (divide_ff) begin
            // carry out means no borrow: quotient bit is one
            hi_in = add_sum[MW+1] ? add_sum[MW:0] : add_x;
            lo_in = {lo_ff[MW-2:0], add_sum[MW+1]};
         end else begin
            hi_in = add_sum[MW+1:1];
            lo_in = {add_sum[0], lo_ff[MW-1:1]};
         end
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      divide_ff <= divide_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      opnd_ff   <= opnd_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = {hi_ff[MW-1:0], lo_ff};

endmodule

FILE: rtl/keypad_integer_calculator.sv
`timescale 1ns / 1ps

// Keypad integer calculator: nine-digit signed four-function calculator with
// one memory register, advanced by one key action per transaction.
// Input channel req_*: req_tuser carries the action code, req_tdata[3:0] the
// digit. Result channel rsp_*: one transaction per key action, reporting
// entry, sign, accumulator, memory, recall and error after that action.
// Digit, memory, clear and add/subtract folds pass through decode (ST_EXEC) and
// write-back (ST_WB); a pending multiply or divide folded with a nonzero entry
// also waits in ST_WAIT and ST_FIN on the shared multiply/divide unit, which
// retires one bit per cycle over 30 bits. One action is in work at a time:
// req_tready is high only when the sequencer is idle.
// The result sits in an output register; the next action is accepted while it
// waits, but its own result holds back until the receiver takes the first.
// Reset (synchronous, active high) clears entry, sign, accumulator, memory
// and pending operation (add) and drops rsp_tvalid.
module keypad_integer_calculator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] digit, [7:4] zero
   input  logic [3:0]  req_tuser,   // [3:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata    // [30:0] entry_value, [31] entry_negative,
                                    // [62:32] accumulator_value,
                                    // [93:63] memory_value, [94] recall_shown,
                                    // [95] error_flag
);

   localparam int VAL_W  = kic_pkg::VAL_W;
   localparam int MAG_W  = kic_pkg::MAG_W;
   localparam int PROD_W = kic_pkg::PROD_W;

   localparam logic [3:0] MAX_DIGIT = 4'd9;

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_WAIT = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_WB   = 3'd4;

   localparam kic_pkg::value_type         VAL_ZERO = '0;
   localparam logic signed [VAL_W+1:0]    LIM_A    = {2'b00, kic_pkg::LIMIT};
   localparam logic signed [VAL_W+3:0]    LIM_D    = {4'b0000, kic_pkg::LIMIT};
   localparam logic        [PROD_W-1:0]   LIM_P    =
      {{(PROD_W-VAL_W){1'b0}}, kic_pkg::LIMIT};

   logic [2:0]         state_ff, state_in;
   logic [3:0]         action_ff, action_in;
   logic [3:0]         digit_ff, digit_in;
   kic_pkg::value_type entry_ff, entry_in;
   kic_pkg::value_type acc_ff, acc_in;
   kic_pkg::value_type mem_ff, mem_in;
   logic               neg_ff, neg_in;
   logic [2:0]         pend_ff, pend_in;
   logic               err_ff, err_in;
   logic               recall_ff, recall_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [95:0]        rsp_data_ff, rsp_data_in;

   kic_pkg::unit_req_type unit_req;
   kic_pkg::unit_rsp_type unit_rsp;

   logic                      req_accept;
   logic                      entry_zero;
   logic                      op_key;
   logic                      mem_key;
   logic                      fold;
   logic                      unit_go;
   logic [2:0]                new_pend;
   kic_pkg::value_type        add_a;
   logic                      add_sub;
   logic signed [VAL_W+1:0]   add_ax, add_ex, add_sum;
   logic                      add_hi, add_lo;
   logic signed [VAL_W+3:0]   dig_ext, dig_dx, dig_sum;
   logic                      dig_ovf;
   kic_pkg::value_type        acc_mag, ent_mag;
   logic                      res_neg;
   logic                      mul_ovf;
   kic_pkg::value_type        res_mag, fin_val;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // key decode
   assign entry_zero = (entry_ff == VAL_ZERO);
   assign op_key     = action_ff inside {[kic_pkg::ACT_ADD:kic_pkg::ACT_DIV]};
   assign mem_key    = (action_ff == kic_pkg::ACT_MADD) || (action_ff == kic_pkg::ACT_MSUB);
   assign fold       = (state_ff == ST_EXEC) &&
                       ((op_key && !entry_zero) || (action_ff == kic_pkg::ACT_EQUAL));
   assign unit_go    = fold && !entry_zero &&
                       ((pend_ff == kic_pkg::PEND_MUL) || (pend_ff == kic_pkg::PEND_DIV));
   assign new_pend   = (action_ff == kic_pkg::ACT_EQUAL) ? kic_pkg::PEND_EQUAL :
                       3'(action_ff - kic_pkg::ACT_ADD);

   // shared add/subtract for accumulator folds and memory updates
   assign add_a   = mem_key ? mem_ff : acc_ff;
   assign add_sub = mem_key ? (action_ff == kic_pkg::ACT_MSUB) :
                              (pend_ff == kic_pkg::PEND_SUB);
   assign add_ax  = {{2{add_a[VAL_W-1]}}, add_a};
   assign add_ex  = {{2{entry_ff[VAL_W-1]}}, entry_ff};
   assign add_sum = add_sub ? (add_ax - add_ex) : (add_ax + add_ex);
   assign add_hi  = (add_sum > LIM_A);
   assign add_lo  = (add_sum < -LIM_A);

   // digit entry: entry*10 +/- digit
   assign dig_ext = {{4{entry_ff[VAL_W-1]}}, entry_ff};
   assign dig_dx  = {{VAL_W{1'b0}}, digit_ff};
   assign dig_sum = (dig_ext <<< 3) + (dig_ext <<< 1) + (neg_ff ? -dig_dx : dig_dx);
   assign dig_ovf = (dig_sum > LIM_D) || (dig_sum < -LIM_D);

   // operands and result shaping for the shared unit
   assign acc_mag = acc_ff[VAL_W-1] ? -acc_ff : acc_ff;
   assign ent_mag = entry_ff[VAL_W-1] ? -entry_ff : entry_ff;
   assign res_neg = acc_ff[VAL_W-1] ^ entry_ff[VAL_W-1];
   assign mul_ovf = (pend_ff == kic_pkg::PEND_MUL) && (unit_rsp.result > LIM_P);
   assign res_mag = {1'b0, unit_rsp.result[MAG_W-1:0]};
   always_comb begin
      if (mul_ovf) begin
         fin_val = res_neg ? -kic_pkg::LIMIT : kic_pkg::LIMIT;
      end else begin
         fin_val = res_neg ? -res_mag : res_mag;
      end
   end

   assign unit_req.start  = unit_go;
   assign unit_req.divide = (pend_ff == kic_pkg::PEND_DIV);
   assign unit_req.opa    = acc_mag[MAG_W-1:0];
   assign unit_req.opb    = ent_mag[MAG_W-1:0];

   kic_unit u_unit (
      .clock (clock),
      .reset (reset),
      .req   (unit_req),
      .rsp   (unit_rsp)
   );

   // sequencer and calculator state
   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      digit_in     = digit_ff;
      entry_in     = entry_ff;
      acc_in       = acc_ff;
      mem_in       = mem_ff;
      neg_in       = neg_ff;
      pend_in      = pend_ff;
      err_in       = err_ff;
      recall_in    = recall_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               action_in = req_tuser;
               digit_in  = req_tdata[3:0];
               err_in    = 1'b0;
               recall_in = 1'b0;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_WB;
            case (action_ff)
               kic_pkg::ACT_DIGIT: begin
                  if (digit_ff <= MAX_DIGIT) begin
                     if (dig_ovf) begin
                        err_in = 1'b1;
                     end else begin
                        entry_in = dig_sum[VAL_W-1:0];
                     end
                  end
               end
               kic_pkg::ACT_ADD, kic_pkg::ACT_SUB, kic_pkg::ACT_MUL, kic_pkg::ACT_DIV: begin
                  if (entry_zero) begin
                     neg_in = (action_ff == kic_pkg::ACT_SUB);
                  end
               end
               kic_pkg::ACT_CLEAR: begin
                  entry_in = VAL_ZERO;
                  acc_in   = VAL_ZERO;
                  pend_in  = kic_pkg::PEND_ADD;
                  neg_in   = 1'b0;
               end
               kic_pkg::ACT_MCLR: begin
                  mem_in = VAL_ZERO;
               end
               kic_pkg::ACT_MRCL: begin
                  recall_in = 1'b1;
               end
               kic_pkg::ACT_MADD, kic_pkg::ACT_MSUB: begin
                  if (add_hi || add_lo) begin
                     err_in = 1'b1;
                  end else begin
                     mem_in = add_sum[VAL_W-1:0];
                  end
               end
               default: begin
               end
            endcase
            // fold the entry into the accumulator
            if (fold) begin
               case (pend_ff)
                  kic_pkg::PEND_ADD, kic_pkg::PEND_SUB: begin
                     if (add_hi) begin
                        acc_in = kic_pkg::LIMIT;
                        err_in = 1'b1;
                     end else if (add_lo) begin
                        acc_in = -kic_pkg::LIMIT;
                        err_in = 1'b1;
                     end else begin
                        acc_in = add_sum[VAL_W-1:0];
                     end
                  end
                  kic_pkg::PEND_MUL: begin
                     if (entry_zero) begin
                        acc_in = VAL_ZERO;
                     end
                  end
                  kic_pkg::PEND_DIV: begin
                     if (entry_zero) begin
                        acc_in = kic_pkg::LIMIT;
                        err_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               if (unit_go) begin
                  state_in = ST_WAIT;
               end else begin
                  pend_in  = new_pend;
                  entry_in = VAL_ZERO;
                  neg_in   = 1'b0;
               end
            end
         end
         ST_WAIT: begin
            if (unit_rsp.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            acc_in   = fin_val;
            err_in   = mul_ovf;
            pend_in  = new_pend;
            entry_in = VAL_ZERO;
            neg_in   = 1'b0;
            state_in = ST_WB;
         end
         ST_WB: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {err_ff, recall_ff, mem_ff, acc_ff, neg_ff, entry_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entry_ff     <= '0;
         acc_ff       <= '0;
         mem_ff       <= '0;
         neg_ff       <= 1'b0;
         pend_ff      <= kic_pkg::PEND_ADD;
         err_ff       <= 1'b0;
         recall_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entry_ff     <= entry_in;
         acc_ff       <= acc_in;
         mem_ff       <= mem_in;
         neg_ff       <= neg_in;
         pend_ff      <= pend_in;
         err_ff       <= err_in;
         recall_ff    <= recall_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff   <= action_in;
      digit_ff    <= digit_in;
      rsp_data_ff <= rsp_data_in;
   end

   // entry never leaves the nine-digit range
   a_entry_range: assert property (@(posedge clock) disable iff (reset)
      (entry_ff <= kic_pkg::LIMIT) && (entry_ff >= -kic_pkg::LIMIT))
      else $error("entry out of range");

   // accumulator and memory stay in range
   a_acc_mem_range: assert property (@(posedge clock) disable iff (reset)
      (acc_ff <= kic_pkg::LIMIT) && (acc_ff >= -kic_pkg::LIMIT) &&
      (mem_ff <= kic_pkg::LIMIT) && (mem_ff >= -kic_pkg::LIMIT))
      else $error("accumulator or memory out of range");

   // typed digits follow the entry sign
   a_entry_sign: assert property (@(posedge clock) disable iff (reset)
      neg_ff ? (entry_ff <= VAL_ZERO) : (entry_ff >= VAL_ZERO))
      else $error("entry value disagrees with entry sign");

   // shared unit finishes only while the sequencer waits on it
   a_unit_done: assert property (@(posedge clock) disable iff (reset)
      unit_rsp.done |-> (state_ff == ST_WAIT))
      else $error("unit done outside wait state");

   // an accepted transaction is decoded next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_EXEC))
      else $error("accepted action not executed");

endmodule
